### rtl/rme_pkg.sv
`timescale 1ns / 1ps
package rme_pkg;

  localparam int unsigned RME_WIDTH = 32;
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] MODULUS_RST  = 32'd3233;
  localparam logic [FIELD_W-1:0] PUB_EXP_RST  = 32'd17;
  localparam logic [FIELD_W-1:0] PRIV_EXP_RST = 32'd2753;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_PUB_EXP  = 2'd1,
    CFG_PRIV_EXP = 2'd2
  } rme_cfg_idx_e;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } rme_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_OUT
  } rme_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rme_mm_stat_t;

endpackage

### rtl/rsa_modexp_engine_core.sv
`timescale 1ns / 1ps
// Run time grows with the exponent length and the number of set bits in it,
//   and is set by the bit-serial modular multiplier.
// Zero exponent, or modulus below two, returns without running the multiplier.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Result is shown for one cycle on result_valid_o; the receiver cannot stall it.
// Reset: asynchronous, active low; loads the demonstration key, engine idle.
module rsa_modexp_engine_core #(
  parameter int unsigned WIDTH = rme_pkg::RME_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation_i,
  input  logic [rme_pkg::FIELD_W-1:0]          base_value_i,
  output logic                                 result_valid_o,
  output logic [rme_pkg::FIELD_W-1:0]          power_result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rme_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rme_pkg::FIELD_W-1:0]          cfg_data_i
);
  import rme_pkg::*;

  localparam int unsigned EXT_W = WIDTH + FIELD_W;

  logic [FIELD_W-1:0] mod_q, pub_q, priv_q;

  rme_state_e   state_q, state_d;
  logic         launch_q, launch_d;
  logic [WIDTH-1:0] m_q, m_d;
  logic [WIDTH-1:0] ex_q, ex_d;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] res_q, res_d;

  logic [EXT_W-1:0] m_ext, ex_ext, base_ext, res_ext;
  logic [WIDTH-1:0] m_in, ex_in, base_in;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_res;
  rme_mm_stat_t     mm_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= MODULUS_RST;
      pub_q  <= PUB_EXP_RST;
      priv_q <= PRIV_EXP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODULUS:  mod_q  <= cfg_data_i;
        CFG_PUB_EXP:  pub_q  <= cfg_data_i;
        CFG_PRIV_EXP: priv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign m_ext    = {{WIDTH{1'b0}}, mod_q};
  assign ex_ext   = {{WIDTH{1'b0}}, (operation_i == OP_DECRYPT) ? priv_q : pub_q};
  assign base_ext = {{WIDTH{1'b0}}, base_value_i};
  assign m_in     = m_ext[WIDTH-1:0];
  assign ex_in    = ex_ext[WIDTH-1:0];
  assign base_in  = base_ext[WIDTH-1:0];

  always_comb begin
    case (state_q)
      ST_REDUCE:  mm_a = WIDTH'(1);
      ST_MUL_ACC: mm_a = acc_q;
      default:    mm_a = base_q;
    endcase
  end

  rme_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (launch_q),
    .a_i     (mm_a),
    .b_i     (base_q),
    .m_i     (m_q),
    .stat_o  (mm_stat),
    .res_o   (mm_res)
  );

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    m_d      = m_q;
    ex_d     = ex_q;
    base_d   = base_q;
    acc_d    = acc_q;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (ex_in == '0) begin
            res_d   = WIDTH'(1);
            state_d = ST_OUT;
          end else if (m_in <= WIDTH'(1)) begin
            res_d   = '0;
            state_d = ST_OUT;
          end else begin
            m_d      = m_in;
            ex_d     = ex_in;
            base_d   = base_in;
            launch_d = 1'b1;
            state_d  = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          base_d   = mm_res;
          acc_d    = WIDTH'(1);
          launch_d = 1'b1;
          state_d  = ex_q[0] ? ST_MUL_ACC : ST_SQUARE;
        end
      end
      ST_MUL_ACC: begin
        if (mm_stat.done) begin
          acc_d = mm_res;
          if (ex_q[WIDTH-1:1] == '0) begin
            res_d   = mm_res;
            state_d = ST_OUT;
          end else begin
            launch_d = 1'b1;
            state_d  = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          base_d   = mm_res;
          ex_d     = {1'b0, ex_q[WIDTH-1:1]};
          launch_d = 1'b1;
          state_d  = ex_q[1] ? ST_MUL_ACC : ST_SQUARE;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    ex_q   <= ex_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_OUT);
  assign res_ext        = {{FIELD_W{1'b0}}, res_q};
  assign power_result_o = res_ext[FIELD_W-1:0];

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe not followed by idle");

  a_launch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> !mm_stat.busy && (state_q != ST_IDLE) && (state_q != ST_OUT))
    else $error("multiplier launched outside a multiply step");

endmodule

### rtl/rme_mulmod.sv
`timescale 1ns / 1ps
module rme_mulmod #(
  parameter int unsigned WIDTH = rme_pkg::RME_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WIDTH-1:0]      a_i,
  input  logic [WIDTH-1:0]      b_i,
  input  logic [WIDTH-1:0]      m_i,
  output rme_pkg::rme_mm_stat_t stat_o,
  output logic [WIDTH-1:0]      res_o
);
  import rme_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] m_q, m_d;

  logic [WIDTH:0]   m_ext;
  logic [WIDTH:0]   dbl_sum;
  logic [WIDTH-1:0] dbl_mod;
  logic [WIDTH:0]   add_sum;
  logic [WIDTH-1:0] add_mod;
  logic [WIDTH-1:0] step_res;

  // one MSB-first step: r = 2r mod m, then add a mod m when the bit is set
  always_comb begin
    m_ext   = {1'b0, m_q};
    dbl_sum = {1'b0, r_q} + {1'b0, r_q};
    if (dbl_sum >= m_ext) begin
      dbl_mod = WIDTH'(dbl_sum - m_ext);
    end else begin
      dbl_mod = dbl_sum[WIDTH-1:0];
    end
    add_sum = {1'b0, dbl_mod} + {1'b0, a_q};
    if (add_sum >= m_ext) begin
      add_mod = WIDTH'(add_sum - m_ext);
    end else begin
      add_mod = add_sum[WIDTH-1:0];
    end
    step_res = b_q[WIDTH-1] ? add_mod : dbl_mod;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH - 1);
      r_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
      m_d    = m_i;
    end else if (busy_q) begin
      r_d   = step_res;
      b_d   = {b_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = r_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held for more than one cycle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (r_q < m_q) && (a_q < m_q))
    else $error("multiplier operand or partial result not below modulus");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rme_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned WATCHDOG    = 20000;
  localparam int unsigned TAIL_CYCLES = 2500;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 34;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum bit {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    rme_op_e              op;
    logic [CFG_IDX_W-1:0] idx;
    logic [FIELD_W-1:0]   val;
    bit                   chk;
    logic [FIELD_W-1:0]   want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 operation_i;
  logic [FIELD_W-1:0]   base_value_i;
  logic                 result_valid_o;
  logic [FIELD_W-1:0]   power_result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [FIELD_W-1:0]   cfg_data_i;

  logic [FIELD_W-1:0] modulus_q;
  logic [FIELD_W-1:0] pub_exp_q;
  logic [FIELD_W-1:0] priv_exp_q;
  logic [FIELD_W-1:0] power_q [$];

  bit                 typed_chk;
  logic [FIELD_W-1:0] typed_want;
  bit                 idle_on;

  int unsigned n_items;
  int unsigned n_cfg;
  int unsigned n_err;
  int unsigned quiet;

  row_t steps [30] = '{
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd65,          1'b1, 32'd2790},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd2790,        1'b1, 32'd65},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd0,           1'b1, 32'd0},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd1,           1'b1, 32'd1},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd3233,        1'b1, 32'd0},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd3232,        1'b1, 32'd3232},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd3232,        1'b1, 32'd3232},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'hFFFF_FFFF,   1'b0, 32'd0},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'h8000_0000,   1'b0, 32'd0},
    '{ROW_REG,  OP_ENCRYPT, CFG_SPARE,    32'hFFFF_FFFF,   1'b0, 32'd0},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd65,          1'b1, 32'd2790},
    '{ROW_REG,  OP_ENCRYPT, CFG_PUB_EXP,  32'd0,           1'b0, 32'd0},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd12345,       1'b1, 32'd1},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd65,          1'b0, 32'd0},
    '{ROW_REG,  OP_ENCRYPT, CFG_MODULUS,  32'd1,           1'b0, 32'd0},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd0,           1'b1, 32'd1},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd77,          1'b1, 32'd0},
    '{ROW_REG,  OP_ENCRYPT, CFG_MODULUS,  32'd0,           1'b0, 32'd0},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd5,           1'b1, 32'd0},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'd5,           1'b1, 32'd1},
    '{ROW_REG,  OP_ENCRYPT, CFG_MODULUS,  32'hFFFF_FFFF,   1'b0, 32'd0},
    '{ROW_REG,  OP_ENCRYPT, CFG_PUB_EXP,  32'hFFFF_FFFF,   1'b0, 32'd0},
    '{ROW_REG,  OP_ENCRYPT, CFG_PRIV_EXP, 32'hFFFF_FFFF,   1'b0, 32'd0},
    '{ROW_ITEM, OP_ENCRYPT, CFG_MODULUS,  32'hFFFF_FFFE,   1'b1, 32'hFFFF_FFFE},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'hFFFF_FFFF,   1'b1, 32'd0},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd2,           1'b0, 32'd0},
    '{ROW_REG,  OP_ENCRYPT, CFG_PRIV_EXP, 32'd1,           1'b0, 32'd0},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'hDEAD_BEEF,   1'b1, 32'hDEAD_BEEF},
    '{ROW_REG,  OP_ENCRYPT, CFG_PRIV_EXP, 32'd0,           1'b0, 32'd0},
    '{ROW_ITEM, OP_DECRYPT, CFG_MODULUS,  32'd0,           1'b1, 32'd1}
  };

  rsa_modexp_engine_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .base_value_i   (base_value_i),
    .result_valid_o (result_valid_o),
    .power_result_o (power_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [FIELD_W-1:0] mod_power(logic [FIELD_W-1:0] b,
                                                   logic [FIELD_W-1:0] e,
                                                   logic [FIELD_W-1:0] m);
    logic [63:0]        acc;
    logic [63:0]        sq;
    logic [63:0]        m64;
    logic [FIELD_W-1:0] k;
    if (e == '0) return 1;
    if (m == '0) return '0;
    m64 = {32'd0, m};
    sq  = {32'd0, b} % m64;
    acc = 64'd1 % m64;
    k   = e;
    while (k != '0) begin
      if (k[0]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
      k  = k >> 1;
    end
    return acc[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 1;
      2:       return $urandom_range(2, 255);
      3:       return '1;
      4:       return $urandom | 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void note_error(string msg);
    n_err++;
    if (n_err <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    logic [FIELD_W-1:0] want;
    logic [FIELD_W-1:0] e;
    bit                 progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (result_valid_o) begin
        progress = 1'b1;
        if (power_q.size() == 0) begin
          note_error($sformatf("power_result %h with no transaction outstanding",
                               power_result_o));
        end else begin
          want = power_q.pop_front();
          if (power_result_o !== want)
            note_error($sformatf("power_result mismatch: expected %h got %h",
                                 want, power_result_o));
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        n_items++;
        e = (operation_i == OP_DECRYPT) ? priv_exp_q : pub_exp_q;
        power_q.push_back(typed_chk ? typed_want : mod_power(base_value_i, e, modulus_q));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        n_cfg++;
        case (cfg_index_i)
          CFG_MODULUS:  modulus_q  = cfg_data_i;
          CFG_PUB_EXP:  pub_exp_q  = cfg_data_i;
          CFG_PRIV_EXP: priv_exp_q = cfg_data_i;
          default: ;
        endcase
      end
      quiet = progress ? 0 : quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    int unsigned seen;
    start <= 1'b0;
    while (busy || power_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    seen = n_cfg;
    do @(negedge clk_i); while (n_cfg == seen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic issue(rme_op_e op, logic [FIELD_W-1:0] b, bit chk,
                       logic [FIELD_W-1:0] want);
    int unsigned gap;
    int unsigned seen;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) != 0) begin
        while (busy) @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    base_value_i <= b;
    typed_chk    <= chk;
    typed_want   <= want;
    seen = n_items;
    do @(negedge clk_i); while (n_items == seen);
  endtask

  initial begin
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] m;
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = OP_ENCRYPT;
    base_value_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_MODULUS;
    cfg_data_i   = '0;
    typed_chk    = 1'b0;
    typed_want   = '0;
    idle_on      = 1'b1;
    modulus_q    = MODULUS_RST;
    pub_exp_q    = PUB_EXP_RST;
    priv_exp_q   = PRIV_EXP_RST;
    n_items      = 0;
    n_cfg        = 0;
    n_err        = 0;
    quiet        = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_REG) write_reg(steps[i].idx, steps[i].val);
      else issue(steps[i].op, steps[i].val, steps[i].chk, steps[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       m = $urandom | 32'h8000_0000;
          1:       m = $urandom_range(2, 65535);
          2:       m = $urandom_range(2, 255);
          3:       m = '1;
          4:       m = $urandom_range(0, 1);
          default: m = $urandom;
        endcase
        write_reg(CFG_MODULUS, m);
      end
      if ($urandom_range(0, 3) != 0) write_reg(CFG_PUB_EXP, pick_exponent());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_PRIV_EXP, pick_exponent());
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0:       b = '0;
          1:       b = 1;
          2:       b = modulus_q - 1;
          3:       b = '1;
          4:       b = modulus_q * $urandom_range(1, 3);
          5, 6:    b = (modulus_q != '0) ? $urandom % modulus_q : $urandom;
          default: b = $urandom;
        endcase
        issue(rme_op_e'($urandom_range(0, 1)), b, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (power_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (n_err == 0 && power_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rme_pkg.sv
rtl/rme_mulmod.sv
rtl/rsa_modexp_engine_core.sv
tb/sv/testbench.sv
